### src/assert_macros.svh
// Assertion macros used by the top RTL file of the disk request scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checks that a property holds at every clock edge outside reset.
`define DRS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// Checks that a condition never holds at a clock edge outside reset.
`define DRS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`else

`define DRS_ASSERT(lbl, clk, rstn, prop, msg)
`define DRS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

### src/drs_pkg.sv
// Types, constants and helper functions of the disk request scheduler.
package drs_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int ID_W    = 16;
  localparam int TRACK_W = 16;
  localparam int SUM_W   = 32;
  localparam int POL_W   = 3;

  localparam logic FUNC_ADD      = 1'b0;
  localparam logic FUNC_DISPATCH = 1'b1;

  localparam logic [POL_W-1:0] POL_FIFO  = 3'd0;
  localparam logic [POL_W-1:0] POL_SSTF  = 3'd1;
  localparam logic [POL_W-1:0] POL_LOOK  = 3'd2;
  localparam logic [POL_W-1:0] POL_CLOOK = 3'd3;
  localparam logic [POL_W-1:0] POL_FLOOK = 3'd4;

  typedef enum logic [1:0] {
    STAT_ADDED      = 2'd0,
    STAT_FULL       = 2'd1,
    STAT_DISPATCHED = 2'd2,
    STAT_EMPTY      = 2'd3
  } status_e;

  // Selection key used by one comparator during a table scan.
  typedef enum logic [2:0] {
    SEL_ID   = 3'd0,
    SEL_DIST = 3'd1,
    SEL_UP   = 3'd2,
    SEL_DOWN = 3'd3,
    SEL_ALL  = 3'd4,
    SEL_NONE = 3'd5
  } sel_e;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TRACK_W-1:0] track;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic               ok;
    logic [TRACK_W-1:0] key;
  } key_t;

  typedef struct packed {
    logic               found;
    logic [TRACK_W-1:0] key;
    logic [ID_W-1:0]    id;
    logic [TRACK_W-1:0] track;
    logic [IDX_W-1:0]   slot;
  } best_t;

  function automatic logic [TRACK_W-1:0] abs_diff(logic [TRACK_W-1:0] a,
                                                  logic [TRACK_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  function automatic key_t key_of(sel_e sel, logic [TRACK_W-1:0] t,
                                  logic [TRACK_W-1:0] head);
    key_t r;
    r.ok  = 1'b1;
    r.key = '0;
    unique case (sel)
      SEL_ID:   r.key = '0;
      SEL_DIST: r.key = abs_diff(t, head);
      SEL_UP: begin
        r.ok  = (t >= head);
        r.key = t;
      end
      SEL_DOWN: begin
        r.ok  = (t <= head);
        r.key = ~t;
      end
      SEL_ALL:  r.key = t;
      SEL_NONE: r.ok  = 1'b0;
      default:  r.ok  = 1'b0;
    endcase
    return r;
  endfunction

  // Lowest slot whose valid bit is clear.
  function automatic logic [IDX_W-1:0] first_free(logic [QUEUE_DEPTH-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (!v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage

### src/drs_req_if.sv
// Request channel: one add or dispatch item per handshake.
interface drs_req_if ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [drs_pkg::ID_W-1:0]    req_id;
  logic [drs_pkg::TRACK_W-1:0] req_track;

  modport source (output valid, func, req_id, req_track, input ready);
  modport sink   (input valid, func, req_id, req_track, output ready);
endinterface

### src/drs_rsp_if.sv
// Result channel: one result item per request item.
interface drs_rsp_if ();
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [drs_pkg::ID_W-1:0]    out_id;
  logic [drs_pkg::TRACK_W-1:0] out_track;
  logic [drs_pkg::TRACK_W-1:0] seek_distance;
  logic                         sweeping_up;
  logic [drs_pkg::SUM_W-1:0]   total_movement;

  modport source (output valid, status, out_id, out_track, seek_distance, sweeping_up,
                  total_movement, input ready);
  modport sink   (input valid, status, out_id, out_track, seek_distance, sweeping_up,
                  total_movement, output ready);
endinterface

### src/drs_cfg_if.sv
// Configuration channel carrying the scheduling policy register.
interface drs_cfg_if ();
  logic                       valid;
  logic                       ready;
  logic [drs_pkg::POL_W-1:0] policy;

  modport source (output valid, policy, input ready);
  modport sink   (input valid, policy, output ready);
endinterface

### src/disk_request_scheduler.sv
// Disk request scheduler: a table of pending requests served by a selectable policy.
// Channels: req_i takes items (func 0 adds id and track, func 1 dispatches one request),
// rsp_o returns exactly one result item per request item, cfg_i writes the policy
// register and is always ready; write it only while no item is in flight.
// Requests are stored in a RAM of QUEUE_DEPTH entries; valid and batch bits are flops.
// An add: the accepting edge latches the item, and once the output register is free,
// state S_OP loads the result into it and, unless the table is full, writes the lowest free slot.
// A dispatch reads the RAM one entry per cycle through its single read port, and two
// comparators keep the best candidate for the primary and the fallback key. Its states
// are S_OP (clear), S_SCAN (one read per table entry) and S_COMMIT (result, once the
// output register is free); the request channel is ready only in S_IDLE, so the block
// takes no new item until the current add or dispatch is through.
// The result waits in an output register: the block takes the next item while it
// waits, and holds a finished result in its last state until the receiver takes the
// one before it. Reset empties the table, puts the head on track 0 sweeping up,
// clears the total and selects FIFO; no clearing pass is needed.
`include "assert_macros.svh"

module disk_request_scheduler (
  input  logic clk_i,
  input  logic rst_ni,
  drs_cfg_if.sink   cfg_i,
  drs_req_if.sink   req_i,
  drs_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OP,
    S_SCAN,
    S_COMMIT
  } state_e;

  state_e                         state_q;
  logic                           func_q;
  logic [drs_pkg::ID_W-1:0]       id_q;
  logic [drs_pkg::TRACK_W-1:0]    track_q;
  logic [drs_pkg::CNT_W-1:0]      cnt_q;
  logic [drs_pkg::QUEUE_DEPTH-1:0] valid_q;
  logic [drs_pkg::QUEUE_DEPTH-1:0] batch_q;
  logic [drs_pkg::TRACK_W-1:0]    head_q;
  logic                           dir_q;
  logic [drs_pkg::SUM_W-1:0]      sum_q;
  logic [drs_pkg::POL_W-1:0]      policy_q;
  logic                           rd_vld_q;
  logic [drs_pkg::IDX_W-1:0]      rd_slot_q;

  logic                           out_valid_q;
  drs_pkg::status_e               out_status_q;
  logic [drs_pkg::ID_W-1:0]       out_id_q;
  logic [drs_pkg::TRACK_W-1:0]    out_track_q;
  logic [drs_pkg::TRACK_W-1:0]    out_dist_q;
  logic                           out_dir_q;
  logic [drs_pkg::SUM_W-1:0]      out_sum_q;

  logic [drs_pkg::POL_W-1:0]      pol_eff;
  logic                           sweep_pol;
  logic                           batch_mode;
  drs_pkg::sel_e                  sel_a, sel_b;
  drs_pkg::best_t                 best_a, best_b, chosen;
  drs_pkg::entry_t                rd_entry, wr_entry;
  logic                           out_free;
  logic                           out_load;
  logic                           full;
  logic [drs_pkg::IDX_W-1:0]      free_slot;
  logic                           ram_we, ram_re;
  logic [drs_pkg::IDX_W-1:0]      ram_raddr;
  logic                           scan_clear;
  logic                           eligible;
  logic [drs_pkg::TRACK_W-1:0]    seek_dist;
  logic [drs_pkg::SUM_W:0]        sum_wide;
  logic [drs_pkg::SUM_W-1:0]      sum_next;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign out_load    = out_free && (((state_q == S_OP) && (func_q == drs_pkg::FUNC_ADD)) ||
                                    (state_q == S_COMMIT));

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.out_id         = out_id_q;
  assign rsp_o.out_track      = out_track_q;
  assign rsp_o.seek_distance  = out_dist_q;
  assign rsp_o.sweeping_up    = out_dir_q;
  assign rsp_o.total_movement = out_sum_q;

  // Unused policy codes behave as FIFO.
  assign pol_eff    = (policy_q > drs_pkg::POL_FLOOK) ? drs_pkg::POL_FIFO : policy_q;
  assign sweep_pol  = (pol_eff == drs_pkg::POL_LOOK) || (pol_eff == drs_pkg::POL_FLOOK);
  assign batch_mode = (pol_eff == drs_pkg::POL_FLOOK);

  always_comb begin
    sel_a = drs_pkg::SEL_ID;
    sel_b = drs_pkg::SEL_NONE;
    unique case (pol_eff)
      drs_pkg::POL_FIFO: sel_a = drs_pkg::SEL_ID;
      drs_pkg::POL_SSTF: sel_a = drs_pkg::SEL_DIST;
      drs_pkg::POL_CLOOK: begin
        sel_a = drs_pkg::SEL_UP;
        sel_b = drs_pkg::SEL_ALL;
      end
      drs_pkg::POL_LOOK, drs_pkg::POL_FLOOK: begin
        sel_a = dir_q ? drs_pkg::SEL_UP : drs_pkg::SEL_DOWN;
        sel_b = dir_q ? drs_pkg::SEL_DOWN : drs_pkg::SEL_UP;
      end
      default: sel_a = drs_pkg::SEL_ID;
    endcase
  end

  assign full      = &valid_q;
  assign free_slot = drs_pkg::first_free(valid_q);

  assign wr_entry.id    = id_q;
  assign wr_entry.track = track_q;

  assign ram_we    = (state_q == S_OP) && (func_q == drs_pkg::FUNC_ADD) && out_free && !full;
  assign ram_re    = (state_q == S_SCAN) && (cnt_q < drs_pkg::CNT_W'(drs_pkg::QUEUE_DEPTH));
  assign ram_raddr = cnt_q[drs_pkg::IDX_W-1:0];

  drs_ram #(
    .WIDTH (drs_pkg::ENTRY_W),
    .DEPTH (drs_pkg::QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (free_slot),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  assign scan_clear = (state_q == S_OP);
  assign eligible   = valid_q[rd_slot_q] && (!batch_mode || batch_q[rd_slot_q]);

  drs_pick u_pick_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (scan_clear),
    .step_i     (rd_vld_q),
    .eligible_i (eligible),
    .sel_i      (sel_a),
    .head_i     (head_q),
    .entry_i    (rd_entry),
    .slot_i     (rd_slot_q),
    .best_o     (best_a)
  );

  drs_pick u_pick_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (scan_clear),
    .step_i     (rd_vld_q),
    .eligible_i (eligible),
    .sel_i      (sel_b),
    .head_i     (head_q),
    .entry_i    (rd_entry),
    .slot_i     (rd_slot_q),
    .best_o     (best_b)
  );

  assign chosen    = best_a.found ? best_a : best_b;
  assign seek_dist = drs_pkg::abs_diff(chosen.track, head_q);
  assign sum_wide  = {1'b0, sum_q} +
                     {{(drs_pkg::SUM_W + 1 - drs_pkg::TRACK_W){1'b0}}, seek_dist};
  assign sum_next  = sum_wide[drs_pkg::SUM_W] ? {drs_pkg::SUM_W{1'b1}}
                                              : sum_wide[drs_pkg::SUM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= drs_pkg::FUNC_ADD;
      cnt_q       <= '0;
      valid_q     <= '0;
      batch_q     <= '0;
      head_q      <= '0;
      dir_q       <= 1'b1;
      sum_q       <= '0;
      policy_q    <= drs_pkg::POL_FIFO;
      rd_vld_q    <= 1'b0;
      rd_slot_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        policy_q <= cfg_i.policy;
      end
      rd_vld_q  <= ram_re;
      rd_slot_q <= ram_raddr;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            func_q  <= req_i.func;
            id_q    <= req_i.req_id;
            track_q <= req_i.req_track;
            state_q <= S_OP;
          end
        end
        S_OP: begin
          if (func_q == drs_pkg::FUNC_ADD) begin
            if (out_free) begin
              if (!full) begin
                valid_q[free_slot] <= 1'b1;
                batch_q[free_slot] <= 1'b0;
              end
              out_status_q <= full ? drs_pkg::STAT_FULL : drs_pkg::STAT_ADDED;
              out_id_q     <= '0;
              out_track_q  <= '0;
              out_dist_q   <= '0;
              out_dir_q    <= dir_q;
              out_sum_q    <= sum_q;
              state_q      <= S_IDLE;
            end
          end else begin
            // An exhausted frozen batch takes in every pending request and restarts upward.
            if (batch_mode && !(|(valid_q & batch_q))) begin
              batch_q <= valid_q;
              dir_q   <= 1'b1;
            end
            cnt_q   <= '0;
            state_q <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_q == drs_pkg::CNT_W'(drs_pkg::QUEUE_DEPTH)) begin
            state_q <= S_COMMIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            state_q <= S_IDLE;
            if (chosen.found) begin
              valid_q[chosen.slot] <= 1'b0;
              batch_q[chosen.slot] <= 1'b0;
              head_q               <= chosen.track;
              sum_q                <= sum_next;
              out_status_q         <= drs_pkg::STAT_DISPATCHED;
              out_id_q             <= chosen.id;
              out_track_q          <= chosen.track;
              out_dist_q           <= seek_dist;
              out_sum_q            <= sum_next;
              // A sweep that finds nothing ahead turns around.
              if (sweep_pol && !best_a.found) begin
                dir_q     <= !dir_q;
                out_dir_q <= !dir_q;
              end else begin
                out_dir_q <= dir_q;
              end
            end else begin
              out_status_q <= drs_pkg::STAT_EMPTY;
              out_id_q     <= '0;
              out_track_q  <= '0;
              out_dist_q   <= '0;
              out_dir_q    <= dir_q;
              out_sum_q    <= sum_q;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `DRS_ASSERT_NEVER(a_batch_subset, clk_i, rst_ni, |(batch_q & ~valid_q),
                    "batch bit set on a free slot")
  `DRS_ASSERT(a_sum_monotone, clk_i, rst_ni, (sum_q >= $past(sum_q)),
              "total movement decreased")
  `DRS_ASSERT(a_add_fills, clk_i, rst_ni,
              ram_we |=> ($countones(valid_q) == $past($countones(valid_q)) + 1),
              "add did not fill one slot")
  `DRS_ASSERT(a_dispatch_frees, clk_i, rst_ni,
              ((state_q == S_COMMIT) && out_free && chosen.found) |=>
                !valid_q[$past(chosen.slot)],
              "dispatched slot still valid")

endmodule

### src/drs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module drs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/drs_pick.sv
// Running best-candidate tracker fed with one table entry per cycle while step_i is high.
module drs_pick (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic                         step_i,
  input  logic                         eligible_i,
  input  drs_pkg::sel_e                sel_i,
  input  logic [drs_pkg::TRACK_W-1:0] head_i,
  input  drs_pkg::entry_t              entry_i,
  input  logic [drs_pkg::IDX_W-1:0]   slot_i,
  output drs_pkg::best_t               best_o
);

  drs_pkg::best_t best_q, best_d;
  drs_pkg::key_t  kr;
  logic           take;

  always_comb begin
    kr   = drs_pkg::key_of(sel_i, entry_i.track, head_i);
    // Entries arrive in slot order, so strict compares keep the lowest slot on a full tie.
    take = step_i && eligible_i && kr.ok &&
           (!best_q.found || (kr.key < best_q.key) ||
            ((kr.key == best_q.key) && (entry_i.id < best_q.id)));
    best_d = best_q;
    if (clear_i) begin
      best_d.found = 1'b0;
    end else if (take) begin
      best_d.found = 1'b1;
      best_d.key   = kr.key;
      best_d.id    = entry_i.id;
      best_d.track = entry_i.track;
      best_d.slot  = slot_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule

### tb/disk_request_scheduler_test.sv
// Self-checking testbench for the disk request scheduler with its own scheduling predictor.
`timescale 1ns / 100ps

module disk_request_scheduler_test;

  localparam logic [drs_pkg::POL_W-1:0] POL_RESERVED_LO = 3'd5;
  localparam logic [drs_pkg::POL_W-1:0] POL_RESERVED_HI = 3'd7;
  localparam int RANDOM_PHASES = 14;
  localparam int PHASE_ITEMS   = 140;
  localparam int DRAIN_CYCLES  = 2 * (drs_pkg::QUEUE_DEPTH + 4);
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PRINT_LIMIT   = 40;

  typedef struct {
    logic                        func;
    logic [drs_pkg::ID_W-1:0]    id;
    logic [drs_pkg::TRACK_W-1:0] track;
  } disk_req_t;

  typedef struct {
    drs_pkg::status_e            status;
    logic [drs_pkg::ID_W-1:0]    id;
    logic [drs_pkg::TRACK_W-1:0] track;
    logic [drs_pkg::TRACK_W-1:0] moved;
    logic                        up;
    logic [drs_pkg::SUM_W-1:0]   total;
  } sched_result_t;

  logic clk = 1'b0;
  logic rst_n;

  drs_req_if req_ch ();
  drs_rsp_if rsp_ch ();
  drs_cfg_if cfg_ch ();

  disk_request_scheduler i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_ch),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stimulus and expectation stores.
  disk_req_t     pending_reqs[$];
  sched_result_t expected_results[$];
  int unsigned   items_queued, items_accepted, results_checked, mismatch_count;
  int unsigned   cycle_count, policy_writes;
  int unsigned   n_added, n_dropped, n_dispatched, n_idle_dispatch;
  bit            hit_ceiling;

  // Sender and receiver pacing.
  bit          sender_gaps;
  int unsigned gap_left, burst_left;
  int unsigned stall_mode;
  logic [3:0]  stall_pos;
  logic [15:0] stall_pattern;
  logic [drs_pkg::ID_W-1:0] next_id;

  // Predictor state.
  logic [drs_pkg::POL_W-1:0]   sched_policy;
  bit                          slot_used[drs_pkg::QUEUE_DEPTH];
  logic [drs_pkg::ID_W-1:0]    slot_id[drs_pkg::QUEUE_DEPTH];
  logic [drs_pkg::TRACK_W-1:0] slot_track[drs_pkg::QUEUE_DEPTH];
  bit                          slot_batch[drs_pkg::QUEUE_DEPTH];
  logic [drs_pkg::TRACK_W-1:0] head;
  bit                          heading_up;
  logic [drs_pkg::SUM_W-1:0]   travel;

  // Best valid slot for a selection key; ties go to the lower id, then the lower slot.
  function automatic int pick_slot(drs_pkg::sel_e mode, bit batch_only);
    int          best;
    int unsigned key, best_key;
    logic [drs_pkg::ID_W-1:0] best_id;
    best = -1;
    best_key = 0;
    best_id = '0;
    for (int i = 0; i < drs_pkg::QUEUE_DEPTH; i++) begin
      if (!slot_used[i] || (batch_only && !slot_batch[i])) continue;
      case (mode)
        drs_pkg::SEL_ID: key = 0;
        drs_pkg::SEL_DIST: begin
          key = (slot_track[i] >= head) ? slot_track[i] - head : head - slot_track[i];
        end
        drs_pkg::SEL_UP: begin
          if (slot_track[i] < head) continue;
          key = slot_track[i];
        end
        drs_pkg::SEL_DOWN: begin
          if (slot_track[i] > head) continue;
          key = 16'hFFFF - slot_track[i];
        end
        default: key = slot_track[i];
      endcase
      if (best < 0 || key < best_key || (key == best_key && slot_id[i] < best_id)) begin
        best = i;
        best_key = key;
        best_id = slot_id[i];
      end
    end
    return best;
  endfunction

  // One LOOK step: keep going in the current direction, reverse when nothing is ahead.
  function automatic int sweep_slot(bit batch_only);
    int s;
    if (heading_up) begin
      s = pick_slot(drs_pkg::SEL_UP, batch_only);
      if (s < 0) begin
        heading_up = 1'b0;
        s = pick_slot(drs_pkg::SEL_DOWN, batch_only);
      end
    end else begin
      s = pick_slot(drs_pkg::SEL_DOWN, batch_only);
      if (s < 0) begin
        heading_up = 1'b1;
        s = pick_slot(drs_pkg::SEL_UP, batch_only);
      end
    end
    return s;
  endfunction

  function automatic sched_result_t serve_request(logic func, logic [drs_pkg::ID_W-1:0] id,
                                                  logic [drs_pkg::TRACK_W-1:0] trk);
    sched_result_t               r;
    logic [drs_pkg::POL_W-1:0]   pol;
    bit                          batch_only, any_left;
    int                          s;
    logic [drs_pkg::TRACK_W-1:0] moved;
    r.status = drs_pkg::STAT_FULL;
    r.id = '0;
    r.track = '0;
    r.moved = '0;
    if (func == drs_pkg::FUNC_ADD) begin
      for (int i = 0; i < drs_pkg::QUEUE_DEPTH; i++) begin
        if (!slot_used[i]) begin
          slot_used[i] = 1'b1;
          slot_id[i] = id;
          slot_track[i] = trk;
          slot_batch[i] = 1'b0;
          r.status = drs_pkg::STAT_ADDED;
          break;
        end
      end
    end else begin
      pol = (sched_policy > drs_pkg::POL_FLOOK) ? drs_pkg::POL_FIFO : sched_policy;
      batch_only = (pol == drs_pkg::POL_FLOOK);
      // An exhausted frozen batch is refilled from the whole table, even an empty one.
      if (batch_only) begin
        any_left = 1'b0;
        for (int i = 0; i < drs_pkg::QUEUE_DEPTH; i++) begin
          if (slot_used[i] && slot_batch[i]) any_left = 1'b1;
        end
        if (!any_left) begin
          for (int i = 0; i < drs_pkg::QUEUE_DEPTH; i++) slot_batch[i] = slot_used[i];
          heading_up = 1'b1;
        end
      end
      any_left = 1'b0;
      for (int i = 0; i < drs_pkg::QUEUE_DEPTH; i++) begin
        if (slot_used[i] && (!batch_only || slot_batch[i])) any_left = 1'b1;
      end
      s = -1;
      if (any_left) begin
        case (pol)
          drs_pkg::POL_FIFO: s = pick_slot(drs_pkg::SEL_ID, 1'b0);
          drs_pkg::POL_SSTF: s = pick_slot(drs_pkg::SEL_DIST, 1'b0);
          drs_pkg::POL_CLOOK: begin
            s = pick_slot(drs_pkg::SEL_UP, 1'b0);
            if (s < 0) s = pick_slot(drs_pkg::SEL_ALL, 1'b0);
          end
          default: s = sweep_slot(batch_only);
        endcase
      end
      if (s < 0) begin
        r.status = drs_pkg::STAT_EMPTY;
      end else begin
        moved = (slot_track[s] >= head) ? slot_track[s] - head : head - slot_track[s];
        r.status = drs_pkg::STAT_DISPATCHED;
        r.id = slot_id[s];
        r.track = slot_track[s];
        r.moved = moved;
        head = slot_track[s];
        slot_used[s] = 1'b0;
        slot_batch[s] = 1'b0;
        if (travel > 32'hFFFF_FFFF - moved) travel = '1;
        else travel = travel + moved;
      end
    end
    r.up = heading_up;
    r.total = travel;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] result %0d: %s is %h, expected %h", $realtime, results_checked, what,
               got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Predictor feed: policy writes and accepted request items.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        sched_policy = cfg_ch.policy;
        policy_writes++;
      end
      if (req_ch.valid && req_ch.ready) begin
        expected_results.insert(expected_results.size(),
                                serve_request(req_ch.func, req_ch.req_id, req_ch.req_track));
        items_accepted++;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    sched_result_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item, status", 32'(rsp_ch.status), '0);
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(rsp_ch.status), 32'(want.status));
        check_field("out_id", 32'(rsp_ch.out_id), 32'(want.id));
        check_field("out_track", 32'(rsp_ch.out_track), 32'(want.track));
        check_field("seek_distance", 32'(rsp_ch.seek_distance), 32'(want.moved));
        check_field("sweeping_up", 32'(rsp_ch.sweeping_up), 32'(want.up));
        check_field("total_movement", rsp_ch.total_movement, want.total);
        case (want.status)
          drs_pkg::STAT_ADDED:      n_added++;
          drs_pkg::STAT_FULL:       n_dropped++;
          drs_pkg::STAT_DISPATCHED: n_dispatched++;
          default:                  n_idle_dispatch++;
        endcase
        if (want.total == '1) hit_ceiling = 1'b1;
      end
      results_checked++;
    end
  end

  // Request driver: bursts of items, separated by random gaps when sender_gaps is set.
  always @(posedge clk) begin
    disk_req_t nxt;
    if (rst_n && (!req_ch.valid || req_ch.ready)) begin
      if (gap_left != 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        req_ch.valid     <= 1'b1;
        req_ch.func      <= nxt.func;
        req_ch.req_id    <= nxt.id;
        req_ch.req_track <= nxt.track;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = sender_gaps ? $urandom_range(1, 10) : 0;
        end else begin
          burst_left--;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: ready follows a random bit pattern unless stalls are off.
  always @(posedge clk) begin
    if (rst_n) begin
      rsp_ch.ready <= (stall_mode == 0) || stall_pattern[stall_pos];
      stall_pos = stall_pos + 4'd1;
      if (stall_pos == 4'd0) begin
        stall_pattern = 16'($urandom);
        if (stall_mode == 2) stall_pattern &= 16'($urandom);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic queue_item(logic func, logic [drs_pkg::ID_W-1:0] id,
                            logic [drs_pkg::TRACK_W-1:0] trk);
    disk_req_t it;
    it.func = func;
    it.id = id;
    it.track = trk;
    pending_reqs.insert(pending_reqs.size(), it);
    items_queued++;
  endtask

  task automatic queue_add(logic [drs_pkg::TRACK_W-1:0] trk);
    // Ids normally rise in arrival order; now and then one is arbitrary.
    if ($urandom_range(0, 19) == 0) begin
      queue_item(drs_pkg::FUNC_ADD, drs_pkg::ID_W'($urandom), trk);
    end else begin
      queue_item(drs_pkg::FUNC_ADD, next_id, trk);
      next_id += drs_pkg::ID_W'($urandom_range(1, 128));
    end
  endtask

  task automatic queue_dispatch();
    queue_item(drs_pkg::FUNC_DISPATCH, drs_pkg::ID_W'($urandom), drs_pkg::TRACK_W'($urandom));
  endtask

  function automatic logic [drs_pkg::TRACK_W-1:0] random_track(
      logic [drs_pkg::TRACK_W-1:0] base);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 1) ? '1 : '0;
    if (r < 5) return base + drs_pkg::TRACK_W'($urandom_range(0, 15));
    return drs_pkg::TRACK_W'($urandom);
  endfunction

  task automatic wait_drained();
    do @(posedge clk);
    while (items_accepted != items_queued || expected_results.size() != 0);
  endtask

  task automatic write_policy(logic [drs_pkg::POL_W-1:0] pol);
    wait_drained();
    cfg_ch.valid  <= 1'b1;
    cfg_ch.policy <= pol;
    do @(posedge clk);
    while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly fill-then-drain runs of random length, with single random items between them.
  task automatic queue_phase(int unsigned n_items);
    int unsigned made, adds, drains;
    logic [drs_pkg::TRACK_W-1:0] base;
    made = 0;
    base = drs_pkg::TRACK_W'($urandom);
    while (made < n_items) begin
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 1)) queue_dispatch();
        else queue_add(random_track(base));
        made++;
      end else begin
        adds = $urandom_range(1, drs_pkg::QUEUE_DEPTH + 2);
        drains = $urandom_range(1, drs_pkg::QUEUE_DEPTH + 2);
        repeat (adds) queue_add(random_track(base));
        repeat (drains) queue_dispatch();
        made += adds + drains;
      end
    end
  endtask

  logic [drs_pkg::TRACK_W-1:0] first_tracks[17] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF,
                                                    16'h0000, 16'h5555, 16'hAAAA, 16'h0001,
                                                    16'hFFFE, 16'h8000, 16'h0100, 16'h4000,
                                                    16'hC000, 16'h8001, 16'h0010, 16'hFFFF,
                                                    16'h1234};
  logic [drs_pkg::POL_W-1:0] phase_policy[8] = '{drs_pkg::POL_SSTF, drs_pkg::POL_LOOK,
                                                 drs_pkg::POL_CLOOK, drs_pkg::POL_FLOOK,
                                                 drs_pkg::POL_FIFO, POL_RESERVED_LO,
                                                 drs_pkg::POL_FLOOK, POL_RESERVED_HI};

  initial begin
    rst_n = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.func = drs_pkg::FUNC_ADD;
    req_ch.req_id = '0;
    req_ch.req_track = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.policy = drs_pkg::POL_FIFO;
    sched_policy = drs_pkg::POL_FIFO;
    for (int i = 0; i < drs_pkg::QUEUE_DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_batch[i] = 1'b0;
    end
    head = '0;
    heading_up = 1'b1;
    travel = '0;
    next_id = '0;
    sender_gaps = 1'b1;
    stall_mode = 1;
    stall_pos = '0;
    stall_pattern = 16'($urandom);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty dispatch, fill past full, FIFO order, FLOOK, reserved policy.
    queue_dispatch();
    for (int k = 0; k < 17; k++) begin
      queue_item(drs_pkg::FUNC_ADD, (k < 15) ? drs_pkg::ID_W'(k * 16'h1000) : '1,
                 first_tracks[k]);
    end
    queue_dispatch();
    queue_dispatch();
    write_policy(drs_pkg::POL_FLOOK);
    queue_dispatch();
    queue_dispatch();
    queue_item(drs_pkg::FUNC_ADD, 16'h0001, 16'h9000);
    write_policy(POL_RESERVED_HI);
    queue_dispatch();
    next_id = 16'h0002;

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_policy((p < 8) ? phase_policy[p] : drs_pkg::POL_W'($urandom_range(0, 7)));
      sender_gaps = (p % 4 != 0);
      stall_mode = (p % 4 == 0) ? 0 : $urandom_range(1, 2);
      queue_phase(PHASE_ITEMS);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results over %0d policy writes: %0d adds, %0d dropped when full,",
             results_checked, policy_writes, n_added, n_dropped);
    $display("%0d dispatches, %0d with nothing pending; movement total saturated: %0d",
             n_dispatched, n_idle_dispatch, hit_ceiling);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/drs_pkg.sv
src/drs_req_if.sv
src/drs_rsp_if.sv
src/drs_cfg_if.sv
src/drs_ram.sv
src/drs_pick.sv
src/disk_request_scheduler.sv
tb/disk_request_scheduler_test.sv
